// File: design/rcpm_pkg.sv
// shared types and constants for the response curve pixel mapper
// no dependencies; used by rcpm_lane, response_curve_pixel_mapper, rcpm_checker and tb
package rcpm_pkg;

   // default sizes of the table
   localparam int TABLE_ENTRIES_DEF = 256;
   localparam int CHANNELS_DEF      = 3;
   localparam int VALUE_BITS_DEF    = 32;

   // channels carried by one request and one response
   localparam int MAP_CHANNELS = 3;

   // fixed field widths
   localparam int FUNC_W    = 2;
   localparam int CHAN_W    = 2;
   localparam int INDEX_W   = 8;
   localparam int IRR_W     = 32;
   localparam int BRIGHT_W  = 8;

   // request function codes
   localparam logic [FUNC_W-1:0] FUNC_LOAD    = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_DIRECT  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_INVERSE = 2'd2;

   // control from the top level to one lane
   typedef struct packed {
      logic wr_en;
      logic search_start;
      logic read_start;
   } lane_ctrl_type;

   // lane sequencer states
   typedef enum logic [1:0] {
      LANE_IDLE,
      LANE_SEARCH,
      LANE_READ
   } lane_state_type;

   // top level states
   typedef enum logic [1:0] {
      MAP_IDLE,
      MAP_RUN,
      MAP_RESP
   } map_state_type;

endpackage

// File: design/rcpm_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
module rcpm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/rcpm_lane.sv
// one channel lane: response table memory plus a lower-bound search sequencer
// depends on rcpm_pkg and rcpm_ram
module rcpm_lane #(
   parameter int TABLE_ENTRIES = rcpm_pkg::TABLE_ENTRIES_DEF,
   parameter int VALUE_BITS    = rcpm_pkg::VALUE_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  rcpm_pkg::lane_ctrl_type          ctrl,
   input  logic [$clog2(TABLE_ENTRIES)-1:0] wr_addr,
   input  logic [VALUE_BITS-1:0]            wr_data,
   input  logic [$clog2(TABLE_ENTRIES)-1:0] rd_addr,
   input  logic [rcpm_pkg::IRR_W-1:0]       value,
   output logic                             done,
   output logic [$clog2(TABLE_ENTRIES)-1:0] index,
   output logic [VALUE_BITS-1:0]            data
);

   import rcpm_pkg::*;

   localparam int AW = $clog2(TABLE_ENTRIES);
   localparam int CW = (VALUE_BITS > IRR_W) ? VALUE_BITS : IRR_W;
   localparam logic [AW-1:0] LAST     = AW'(TABLE_ENTRIES - 1);
   localparam logic [AW-1:0] FIRST_MID = AW'((TABLE_ENTRIES - 1) / 2);

   lane_state_type    state_ff, state_in;
   logic [AW-1:0]     first_ff, first_in;
   logic [AW-1:0]     count_ff, count_in;
   logic [AW-1:0]     mid_ff, mid_in;
   logic [IRR_W-1:0]  value_ff, value_in;
   logic [AW-1:0]     index_ff, index_in;
   logic [VALUE_BITS-1:0] data_ff, data_in;
   logic              done_ff, done_in;

   logic                  ram_rd_en;
   logic [AW-1:0]         ram_rd_addr;
   logic [VALUE_BITS-1:0] ram_rd_data;

   logic          less;
   logic [AW-1:0] half;
   logic [AW-1:0] next_first;
   logic [AW-1:0] next_count;
   logic [AW-1:0] next_mid;

   rcpm_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (TABLE_ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ctrl.wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // one probe step: narrow the window around the entry just read
   always_comb begin
      half = count_ff >> 1;
      less = CW'(ram_rd_data) < CW'(value_ff);
      if (less) begin
         next_first = AW'(mid_ff + 1'b1);
         next_count = AW'(count_ff - half - 1'b1);
      end else begin
         next_first = first_ff;
         next_count = half;
      end
      next_mid = AW'(next_first + (next_count >> 1));
   end

   // sequencer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LANE_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      first_ff <= first_in;
      count_ff <= count_in;
      mid_ff   <= mid_in;
      value_ff <= value_in;
      index_ff <= index_in;
      data_ff  <= data_in;
   end

   // next state and memory read control
   always_comb begin
      state_in    = state_ff;
      first_in    = first_ff;
      count_in    = count_ff;
      mid_in      = mid_ff;
      value_in    = value_ff;
      index_in    = index_ff;
      data_in     = data_ff;
      done_in     = 1'b0;
      ram_rd_en   = 1'b0;
      ram_rd_addr = mid_ff;
      case (state_ff)
         LANE_IDLE: begin
            if (ctrl.search_start) begin
               value_in    = value;
               first_in    = '0;
               count_in    = LAST;
               mid_in      = FIRST_MID;
               ram_rd_en   = 1'b1;
               ram_rd_addr = FIRST_MID;
               state_in    = LANE_SEARCH;
            end else if (ctrl.read_start) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = rd_addr;
               state_in    = LANE_READ;
            end
         end
         LANE_SEARCH: begin
            first_in = next_first;
            count_in = next_count;
            if (next_count == '0) begin
               index_in = next_first;
               done_in  = 1'b1;
               state_in = LANE_IDLE;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = next_mid;
               mid_in      = next_mid;
            end
         end
         LANE_READ: begin
            data_in  = ram_rd_data;
            done_in  = 1'b1;
            state_in = LANE_IDLE;
         end
         default: begin
            state_in = LANE_IDLE;
         end
      endcase
   end

   assign done  = done_ff;
   assign index = index_ff;
   assign data  = data_ff;

endmodule

// File: design/response_curve_pixel_mapper.sv
// response curve pixel mapper: per channel lanes search or read the response table
// load: no response. inverse map: each lane reads its entry and flags done, then the top
// level gives the response strobe. direct map: binary search at one table probe per cycle,
// ceil(log2(TABLE_ENTRIES)) probes (8 at 256 entries), then each lane flags done and the
// strobe follows. busy stays high until the response strobe has gone; no request is taken while busy.
// reset clears control only; the table holds nothing defined until entries are loaded.
module response_curve_pixel_mapper #(
   parameter int TABLE_ENTRIES = rcpm_pkg::TABLE_ENTRIES_DEF,
   parameter int CHANNELS      = rcpm_pkg::CHANNELS_DEF,
   parameter int VALUE_BITS    = rcpm_pkg::VALUE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [rcpm_pkg::FUNC_W-1:0]   req_func,
   input  logic [rcpm_pkg::CHAN_W-1:0]   req_channel,
   input  logic [rcpm_pkg::INDEX_W-1:0]  req_entry_index,
   input  logic [rcpm_pkg::IRR_W-1:0]    req_entry_value,
   input  logic [rcpm_pkg::IRR_W-1:0]    req_irradiance_red,
   input  logic [rcpm_pkg::IRR_W-1:0]    req_irradiance_green,
   input  logic [rcpm_pkg::IRR_W-1:0]    req_irradiance_blue,
   input  logic [rcpm_pkg::BRIGHT_W-1:0] req_brightness_red,
   input  logic [rcpm_pkg::BRIGHT_W-1:0] req_brightness_green,
   input  logic [rcpm_pkg::BRIGHT_W-1:0] req_brightness_blue,
   output logic                          rsp_valid,
   output logic [rcpm_pkg::BRIGHT_W-1:0] rsp_mapped_brightness_red,
   output logic [rcpm_pkg::BRIGHT_W-1:0] rsp_mapped_brightness_green,
   output logic [rcpm_pkg::BRIGHT_W-1:0] rsp_mapped_brightness_blue,
   output logic [rcpm_pkg::IRR_W-1:0]    rsp_mapped_irradiance_red,
   output logic [rcpm_pkg::IRR_W-1:0]    rsp_mapped_irradiance_green,
   output logic [rcpm_pkg::IRR_W-1:0]    rsp_mapped_irradiance_blue
);

   import rcpm_pkg::*;

   localparam int AW    = $clog2(TABLE_ENTRIES);
   localparam int LANES = (CHANNELS < MAP_CHANNELS) ? CHANNELS : MAP_CHANNELS;

   map_state_type     state_ff, state_in;
   logic              direct_ff, direct_in;
   logic [LANES-1:0]  seen_ff, seen_in;

   logic              accept;
   logic              idx_ok;
   logic [AW-1:0]     wr_addr;
   logic [VALUE_BITS-1:0] wr_data;
   logic [LANES-1:0]  lane_done;

   logic [IRR_W-1:0]    irr_req [MAP_CHANNELS];
   logic [BRIGHT_W-1:0] bri_req [MAP_CHANNELS];
   logic [BRIGHT_W-1:0] bri_rsp [MAP_CHANNELS];
   logic [IRR_W-1:0]    irr_rsp [MAP_CHANNELS];

   // request transfer and load address check
   assign accept  = start && !busy;
   assign idx_ok  = 32'(req_entry_index) < 32'(TABLE_ENTRIES);
   assign wr_addr = AW'(req_entry_index);
   assign wr_data = VALUE_BITS'(req_entry_value);

   assign irr_req[0] = req_irradiance_red;
   assign irr_req[1] = req_irradiance_green;
   assign irr_req[2] = req_irradiance_blue;
   assign bri_req[0] = req_brightness_red;
   assign bri_req[1] = req_brightness_green;
   assign bri_req[2] = req_brightness_blue;

   // channel lanes and response merge
   for (genvar c = 0; c < MAP_CHANNELS; c++) begin : g_chan
      if (c < LANES) begin : g_lane
         lane_ctrl_type         ctrl;
         logic [AW-1:0]         rd_addr;
         logic [AW-1:0]         index;
         logic [VALUE_BITS-1:0] data;

         // saturate the brightness byte at the last entry
         assign rd_addr = (32'(bri_req[c]) < 32'(TABLE_ENTRIES)) ?
                          AW'(bri_req[c]) : AW'(TABLE_ENTRIES - 1);

         assign ctrl.wr_en        = accept && (req_func == FUNC_LOAD) &&
                                    (req_channel == CHAN_W'(c)) && idx_ok;
         assign ctrl.search_start = accept && (req_func == FUNC_DIRECT);
         assign ctrl.read_start   = accept && (req_func == FUNC_INVERSE);

         rcpm_lane #(
            .TABLE_ENTRIES (TABLE_ENTRIES),
            .VALUE_BITS    (VALUE_BITS)
         ) u_lane (
            .clock   (clock),
            .reset   (reset),
            .ctrl    (ctrl),
            .wr_addr (wr_addr),
            .wr_data (wr_data),
            .rd_addr (rd_addr),
            .value   (irr_req[c]),
            .done    (lane_done[c]),
            .index   (index),
            .data    (data)
         );

         assign bri_rsp[c] = direct_ff ? BRIGHT_W'(index) : '0;
         assign irr_rsp[c] = direct_ff ? '0 : IRR_W'(data);
      end else begin : g_none
         assign bri_rsp[c] = '0;
         assign irr_rsp[c] = '0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= MAP_IDLE;
         seen_ff   <= '0;
         direct_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         seen_ff   <= seen_in;
         direct_ff <= direct_in;
      end
   end

   // wait for every lane, then present the response for one cycle
   always_comb begin
      state_in  = state_ff;
      seen_in   = seen_ff;
      direct_in = direct_ff;
      case (state_ff)
         MAP_IDLE: begin
            if (accept && ((req_func == FUNC_DIRECT) || (req_func == FUNC_INVERSE))) begin
               direct_in = (req_func == FUNC_DIRECT);
               seen_in   = '0;
               state_in  = MAP_RUN;
            end
         end
         MAP_RUN: begin
            seen_in = seen_ff | lane_done;
            if (&seen_in) begin
               state_in = MAP_RESP;
            end
         end
         MAP_RESP: begin
            state_in = MAP_IDLE;
         end
         default: begin
            state_in = MAP_IDLE;
         end
      endcase
   end

   assign busy      = (state_ff != MAP_IDLE);
   assign rsp_valid = (state_ff == MAP_RESP);

   assign rsp_mapped_brightness_red   = bri_rsp[0];
   assign rsp_mapped_brightness_green = bri_rsp[1];
   assign rsp_mapped_brightness_blue  = bri_rsp[2];
   assign rsp_mapped_irradiance_red   = irr_rsp[0];
   assign rsp_mapped_irradiance_green = irr_rsp[1];
   assign rsp_mapped_irradiance_blue  = irr_rsp[2];

endmodule

// File: bench/rcpm_checker.sv
// response checker for the response curve pixel mapper bench
// depends on rcpm_pkg; keeps its own copy of the response table and predicts each map
module rcpm_checker #(
   parameter int TABLE_ENTRIES = rcpm_pkg::TABLE_ENTRIES_DEF,
   parameter int CHANNELS      = rcpm_pkg::CHANNELS_DEF,
   parameter int VALUE_BITS    = rcpm_pkg::VALUE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic [rcpm_pkg::FUNC_W-1:0]   req_func,
   input  logic [rcpm_pkg::CHAN_W-1:0]   req_channel,
   input  logic [rcpm_pkg::INDEX_W-1:0]  req_entry_index,
   input  logic [rcpm_pkg::IRR_W-1:0]    req_entry_value,
   input  logic [rcpm_pkg::IRR_W-1:0]    req_irradiance_red,
   input  logic [rcpm_pkg::IRR_W-1:0]    req_irradiance_green,
   input  logic [rcpm_pkg::IRR_W-1:0]    req_irradiance_blue,
   input  logic [rcpm_pkg::BRIGHT_W-1:0] req_brightness_red,
   input  logic [rcpm_pkg::BRIGHT_W-1:0] req_brightness_green,
   input  logic [rcpm_pkg::BRIGHT_W-1:0] req_brightness_blue,
   input  logic                          rsp_valid,
   input  logic [rcpm_pkg::BRIGHT_W-1:0] rsp_mapped_brightness_red,
   input  logic [rcpm_pkg::BRIGHT_W-1:0] rsp_mapped_brightness_green,
   input  logic [rcpm_pkg::BRIGHT_W-1:0] rsp_mapped_brightness_blue,
   input  logic [rcpm_pkg::IRR_W-1:0]    rsp_mapped_irradiance_red,
   input  logic [rcpm_pkg::IRR_W-1:0]    rsp_mapped_irradiance_green,
   input  logic [rcpm_pkg::IRR_W-1:0]    rsp_mapped_irradiance_blue,
   output int unsigned                   fail_count,
   output int unsigned                   outstanding,
   output int unsigned                   checked_count
);
   import rcpm_pkg::*;

   localparam int REPORT_LIMIT = 10;
   localparam logic [IRR_W-1:0] VALUE_MASK =
      (VALUE_BITS >= IRR_W) ? '1 : IRR_W'((64'd1 << VALUE_BITS) - 64'd1);

   typedef struct packed {
      logic [MAP_CHANNELS-1:0][BRIGHT_W-1:0] brightness;
      logic [MAP_CHANNELS-1:0][IRR_W-1:0]    irradiance;
   } map_result_type;

   string chan_name [MAP_CHANNELS] = '{"red", "green", "blue"};

   logic [IRR_W-1:0] curve [CHANNELS][TABLE_ENTRIES];
   map_result_type   pending_maps [$];
   map_result_type   want;
   map_result_type   got;
   int unsigned      errors = 0;
   int unsigned      shown  = 0;
   int unsigned      checked = 0;

   // first position in 0..TABLE_ENTRIES-2 whose entry is not below level, else the last
   function automatic logic [BRIGHT_W-1:0] search_position(int ch, logic [IRR_W-1:0] level);
      int unsigned first;
      int unsigned count;
      int unsigned half;
      int unsigned mid;
      first = 0;
      count = TABLE_ENTRIES - 1;
      while (count > 0) begin
         half = count / 2;
         mid  = first + half;
         if (curve[ch][mid] < level) begin
            first = mid + 1;
            count = count - (half + 1);
         end else begin
            count = half;
         end
      end
      return first[BRIGHT_W-1:0];
   endfunction

   // expected response of one direct or inverse map
   function automatic map_result_type predict_map(
      logic [FUNC_W-1:0]                     func,
      logic [MAP_CHANNELS-1:0][IRR_W-1:0]    irr,
      logic [MAP_CHANNELS-1:0][BRIGHT_W-1:0] bright
   );
      map_result_type res;
      int unsigned    pos;
      res = '0;
      for (int c = 0; c < MAP_CHANNELS; c++) begin
         if (c < CHANNELS) begin
            if (func == FUNC_DIRECT) begin
               res.brightness[c] = search_position(c, irr[c]);
            end else begin
               pos = 32'(bright[c]);
               if (pos >= TABLE_ENTRIES) pos = TABLE_ENTRIES - 1;
               res.irradiance[c] = curve[c][pos];
            end
         end
      end
      return res;
   endfunction

   task automatic note_failure(input string what);
      errors++;
      if (shown < REPORT_LIMIT) begin
         shown++;
         $display("checker: mismatch at %0t: %s", $realtime, what);
      end
   endtask

   // compare responses, then track table writes and new map transfers
   always @(posedge clock) begin
      if (reset) begin
         pending_maps.delete();
      end else begin
         if (rsp_valid) begin
            checked++;
            got.brightness = {rsp_mapped_brightness_blue, rsp_mapped_brightness_green,
                              rsp_mapped_brightness_red};
            got.irradiance = {rsp_mapped_irradiance_blue, rsp_mapped_irradiance_green,
                              rsp_mapped_irradiance_red};
            if (pending_maps.size() == 0) begin
               note_failure("response with no map outstanding");
            end else begin
               want = pending_maps.pop_front();
               for (int c = 0; c < MAP_CHANNELS; c++) begin
                  if (got.brightness[c] !== want.brightness[c])
                     note_failure($sformatf("%s brightness expected %0d got %0d",
                        chan_name[c], want.brightness[c], got.brightness[c]));
                  if (got.irradiance[c] !== want.irradiance[c])
                     note_failure($sformatf("%s irradiance expected %h got %h",
                        chan_name[c], want.irradiance[c], got.irradiance[c]));
               end
            end
         end
         if (start && !busy) begin
            case (req_func)
               FUNC_LOAD: begin
                  if (req_channel < CHANNELS && req_entry_index < TABLE_ENTRIES)
                     curve[req_channel][req_entry_index] = req_entry_value & VALUE_MASK;
               end
               FUNC_DIRECT, FUNC_INVERSE: begin
                  pending_maps.push_back(predict_map(req_func,
                     {req_irradiance_blue, req_irradiance_green, req_irradiance_red},
                     {req_brightness_blue, req_brightness_green, req_brightness_red}));
               end
               default: ;
            endcase
         end
      end
      outstanding   <= pending_maps.size();
      fail_count    <= errors;
      checked_count <= checked;
   end

endmodule

// File: bench/tb.sv
// top of the response curve pixel mapper bench: clock, reset, stimulus and verdict
// depends on rcpm_pkg, response_curve_pixel_mapper and rcpm_checker
module tb;
   import rcpm_pkg::*;

   localparam int TABLE_ENTRIES  = TABLE_ENTRIES_DEF;
   localparam int CHANNELS       = CHANNELS_DEF;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 16;
   localparam int SEGMENT_ITEMS  = 150;
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam logic [CHAN_W-1:0] CHAN_NONE   = 2'd3;
   localparam logic [IRR_W-1:0]  STEP_MAX    = 32'hFFFF_FFFF / TABLE_ENTRIES;

   typedef enum {CURVE_RAMP, CURVE_NOISE, CURVE_EDGES} curve_style_type;

   typedef struct packed {
      logic [FUNC_W-1:0]                     func;
      logic [CHAN_W-1:0]                     channel;
      logic [INDEX_W-1:0]                    index;
      logic [IRR_W-1:0]                      value;
      logic [MAP_CHANNELS-1:0][IRR_W-1:0]    irr;
      logic [MAP_CHANNELS-1:0][BRIGHT_W-1:0] bright;
   } map_req_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic [FUNC_W-1:0]    req_func = FUNC_LOAD;
   logic [CHAN_W-1:0]    req_channel = '0;
   logic [INDEX_W-1:0]   req_entry_index = '0;
   logic [IRR_W-1:0]     req_entry_value = '0;
   logic [IRR_W-1:0]     req_irradiance_red = '0;
   logic [IRR_W-1:0]     req_irradiance_green = '0;
   logic [IRR_W-1:0]     req_irradiance_blue = '0;
   logic [BRIGHT_W-1:0]  req_brightness_red = '0;
   logic [BRIGHT_W-1:0]  req_brightness_green = '0;
   logic [BRIGHT_W-1:0]  req_brightness_blue = '0;
   logic                 rsp_valid;
   logic [BRIGHT_W-1:0]  rsp_mapped_brightness_red;
   logic [BRIGHT_W-1:0]  rsp_mapped_brightness_green;
   logic [BRIGHT_W-1:0]  rsp_mapped_brightness_blue;
   logic [IRR_W-1:0]     rsp_mapped_irradiance_red;
   logic [IRR_W-1:0]     rsp_mapped_irradiance_green;
   logic [IRR_W-1:0]     rsp_mapped_irradiance_blue;

   int unsigned fail_count;
   int unsigned outstanding;
   int unsigned checked_count;

   // stimulus-side copy of what has been loaded, used to aim irradiances
   logic [IRR_W-1:0] shadow [CHANNELS][TABLE_ENTRIES];
   bit               idle_on = 1'b1;
   int unsigned      n_load = 0;
   int unsigned      n_dropped = 0;
   int unsigned      n_direct = 0;
   int unsigned      n_inverse = 0;
   int unsigned      n_unused = 0;

   always #6 clock = ~clock;

   response_curve_pixel_mapper #(
      .TABLE_ENTRIES(TABLE_ENTRIES),
      .CHANNELS     (CHANNELS)
   ) u_top (
      .clock                      (clock),
      .reset                      (reset),
      .start                      (start),
      .busy                       (busy),
      .req_func                   (req_func),
      .req_channel                (req_channel),
      .req_entry_index            (req_entry_index),
      .req_entry_value            (req_entry_value),
      .req_irradiance_red         (req_irradiance_red),
      .req_irradiance_green       (req_irradiance_green),
      .req_irradiance_blue        (req_irradiance_blue),
      .req_brightness_red         (req_brightness_red),
      .req_brightness_green       (req_brightness_green),
      .req_brightness_blue        (req_brightness_blue),
      .rsp_valid                  (rsp_valid),
      .rsp_mapped_brightness_red  (rsp_mapped_brightness_red),
      .rsp_mapped_brightness_green(rsp_mapped_brightness_green),
      .rsp_mapped_brightness_blue (rsp_mapped_brightness_blue),
      .rsp_mapped_irradiance_red  (rsp_mapped_irradiance_red),
      .rsp_mapped_irradiance_green(rsp_mapped_irradiance_green),
      .rsp_mapped_irradiance_blue (rsp_mapped_irradiance_blue)
   );

   rcpm_checker #(
      .TABLE_ENTRIES(TABLE_ENTRIES),
      .CHANNELS     (CHANNELS)
   ) u_check (
      .clock                      (clock),
      .reset                      (reset),
      .start                      (start),
      .busy                       (busy),
      .req_func                   (req_func),
      .req_channel                (req_channel),
      .req_entry_index            (req_entry_index),
      .req_entry_value            (req_entry_value),
      .req_irradiance_red         (req_irradiance_red),
      .req_irradiance_green       (req_irradiance_green),
      .req_irradiance_blue        (req_irradiance_blue),
      .req_brightness_red         (req_brightness_red),
      .req_brightness_green       (req_brightness_green),
      .req_brightness_blue        (req_brightness_blue),
      .rsp_valid                  (rsp_valid),
      .rsp_mapped_brightness_red  (rsp_mapped_brightness_red),
      .rsp_mapped_brightness_green(rsp_mapped_brightness_green),
      .rsp_mapped_brightness_blue (rsp_mapped_brightness_blue),
      .rsp_mapped_irradiance_red  (rsp_mapped_irradiance_red),
      .rsp_mapped_irradiance_green(rsp_mapped_irradiance_green),
      .rsp_mapped_irradiance_blue (rsp_mapped_irradiance_blue),
      .fail_count                 (fail_count),
      .outstanding                (outstanding),
      .checked_count              (checked_count)
   );

   // every field random, so unused fields carry noise
   function automatic map_req_type rand_req();
      map_req_type item;
      item.func    = FUNC_W'($urandom_range(0, 3));
      item.channel = CHAN_W'($urandom_range(0, 3));
      item.index   = INDEX_W'($urandom_range(0, TABLE_ENTRIES - 1));
      item.value   = $urandom;
      for (int c = 0; c < MAP_CHANNELS; c++) begin
         item.irr[c]    = $urandom;
         item.bright[c] = BRIGHT_W'($urandom_range(0, 255));
      end
      return item;
   endfunction

   // one transfer, with occasional idle cycles in front of it while idle_on is set
   task automatic send_req(input map_req_type item);
      if (idle_on) begin
         while ($urandom_range(0, 99) < 14) begin
            start <= 1'b0;
            @(posedge clock);
         end
      end
      start                <= 1'b1;
      req_func             <= item.func;
      req_channel          <= item.channel;
      req_entry_index      <= item.index;
      req_entry_value      <= item.value;
      req_irradiance_red   <= item.irr[0];
      req_irradiance_green <= item.irr[1];
      req_irradiance_blue  <= item.irr[2];
      req_brightness_red   <= item.bright[0];
      req_brightness_green <= item.bright[1];
      req_brightness_blue  <= item.bright[2];
      do @(posedge clock); while (busy);
      case (item.func)
         FUNC_LOAD: begin
            if (item.channel < CHANNELS) begin
               shadow[item.channel][item.index] = item.value;
               n_load++;
            end else begin
               n_dropped++;
            end
         end
         FUNC_DIRECT:  n_direct++;
         FUNC_INVERSE: n_inverse++;
         default:      n_unused++;
      endcase
   endtask

   task automatic send_load(input logic [CHAN_W-1:0] ch, input logic [INDEX_W-1:0] idx,
                            input logic [IRR_W-1:0] val);
      map_req_type item;
      item         = rand_req();
      item.func    = FUNC_LOAD;
      item.channel = ch;
      item.index   = idx;
      item.value   = val;
      send_req(item);
   endtask

   task automatic send_direct(input logic [IRR_W-1:0] r, input logic [IRR_W-1:0] g,
                              input logic [IRR_W-1:0] b);
      map_req_type item;
      item      = rand_req();
      item.func = FUNC_DIRECT;
      item.irr  = {b, g, r};
      send_req(item);
   endtask

   task automatic send_inverse(input logic [BRIGHT_W-1:0] r, input logic [BRIGHT_W-1:0] g,
                               input logic [BRIGHT_W-1:0] b);
      map_req_type item;
      item        = rand_req();
      item.func   = FUNC_INVERSE;
      item.bright = {b, g, r};
      send_req(item);
   endtask

   // write every entry of every channel with one curve shape
   task automatic fill_curve(input curve_style_type style);
      logic [IRR_W-1:0] level;
      logic [IRR_W-1:0] step_cap;
      for (int c = 0; c < CHANNELS; c++) begin
         level    = $urandom_range(0, 1000);
         step_cap = STEP_MAX >> $urandom_range(0, 16);
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            case (style)
               CURVE_RAMP: begin
                  send_load(CHAN_W'(c), INDEX_W'(i), level);
                  // flat runs give duplicate entries
                  if ($urandom_range(0, 9) != 0) level = level + $urandom_range(0, step_cap);
               end
               CURVE_NOISE: send_load(CHAN_W'(c), INDEX_W'(i), $urandom);
               default: begin
                  if (c == 0)      send_load(CHAN_W'(c), INDEX_W'(i), '0);
                  else if (c == 1) send_load(CHAN_W'(c), INDEX_W'(i), '1);
                  else             send_load(CHAN_W'(c), INDEX_W'(i),
                                             (i < TABLE_ENTRIES / 2) ? '0 : '1);
               end
            endcase
         end
      end
   endtask

   // fresh curve, then a mix of maps, entry rewrites and ignored items
   task automatic random_segment(input curve_style_type style, input int unsigned count);
      map_req_type      item;
      int unsigned      pick;
      int unsigned      ch;
      int unsigned      idx;
      logic [IRR_W-1:0] lo;
      logic [IRR_W-1:0] hi;
      fill_curve(style);
      repeat (count) begin
         pick = $urandom_range(0, 99);
         item = rand_req();
         if (pick < 40) begin
            item.func = FUNC_DIRECT;
            for (int c = 0; c < MAP_CHANNELS; c++) begin
               idx = $urandom_range(0, TABLE_ENTRIES - 1);
               case ($urandom_range(0, 5))
                  0: item.irr[c] = shadow[c][idx];
                  1: item.irr[c] = shadow[c][idx] + 1;
                  2: item.irr[c] = shadow[c][idx] - 1;
                  3: item.irr[c] = '0;
                  4: item.irr[c] = '1;
                  default: ;
               endcase
            end
         end else if (pick < 70) begin
            item.func = FUNC_INVERSE;
         end else if (pick < 88) begin
            // rewrite mostly keeps the curve non-decreasing
            item.func    = FUNC_LOAD;
            item.channel = CHAN_W'($urandom_range(0, CHANNELS - 1));
            ch  = 32'(item.channel);
            idx = 32'(item.index);
            lo  = (idx > 0) ? shadow[ch][idx - 1] : '0;
            hi  = (idx < TABLE_ENTRIES - 1) ? shadow[ch][idx + 1] : '1;
            if (hi >= lo && $urandom_range(0, 3) != 0)
               item.value = lo + $urandom_range(0, hi - lo);
         end else if (pick < 94) begin
            item.func    = FUNC_LOAD;
            item.channel = CHAN_NONE;
         end else begin
            item.func = FUNC_UNUSED;
         end
         send_req(item);
      end
   endtask

   // cycles in which nothing transfers
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (start && !busy) || rsp_valid) quiet = 0;
         else quiet++;
      end
      $display("tb: watchdog expired with %0d maps outstanding", outstanding);
      $display("tb: failure");
      $finish;
   end

   initial begin : stimulus
      map_req_type item;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // whole table must be written before any map
      fill_curve(CURVE_RAMP);

      // directed: extremes of brightness and irradiance
      send_inverse(8'd0, 8'd0, 8'd0);
      send_inverse(8'd255, 8'd255, 8'd255);
      send_inverse(8'h55, 8'hAA, 8'h0F);
      send_direct('0, '0, '0);
      send_direct('1, '1, '1);
      send_direct(shadow[0][100], shadow[1][17], shadow[2][254]);
      send_direct(shadow[0][254] + 1, shadow[1][0] + 1, shadow[2][200] + 1);
      // unused function code and a load to the missing channel
      item      = rand_req();
      item.func = FUNC_UNUSED;
      send_req(item);
      send_load(CHAN_NONE, 8'd5, '1);
      send_inverse(8'd5, 8'd5, 8'd5);
      // break the ordering of the curve
      send_load(2'd0, 8'd0, '1);
      send_load(2'd2, 8'd255, '0);
      send_inverse(8'd0, 8'd1, 8'd255);
      send_direct(shadow[0][1], 32'd1, '0);
      send_load(2'd1, 8'd127, '0);
      send_direct(shadow[0][128], shadow[1][128], shadow[2][128]);
      // flat and stepped curves
      fill_curve(CURVE_EDGES);
      send_direct('0, '0, '0);
      send_direct(32'd1, '1, 32'd1);
      send_direct('1, 32'd1, '1);
      send_inverse(8'd127, 8'd128, 8'd128);

      // random phases, one of them with no gaps at all
      random_segment(CURVE_RAMP, SEGMENT_ITEMS);
      random_segment(CURVE_NOISE, SEGMENT_ITEMS);
      idle_on = 1'b0;
      random_segment(CURVE_RAMP, SEGMENT_ITEMS);
      idle_on = 1'b1;
      random_segment(CURVE_EDGES, SEGMENT_ITEMS);

      // drain, then watch for stray responses
      start <= 1'b0;
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("tb: %0d entry loads, %0d loads to the missing channel, %0d unused codes",
               n_load, n_dropped, n_unused);
      $display("tb: %0d direct and %0d inverse maps, %0d responses compared",
               n_direct, n_inverse, checked_count);
      if (fail_count == 0 && outstanding == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
